/* rtl/dotq_pkg.sv */
// Shared types and codes for the deadline-ordered timer queue.
// Used by dotq_store, dotq_seq and the top level; no dependencies.
`timescale 1ns / 1ps

package dotq_pkg;

  localparam int unsigned PtrW = 6;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_POP    = 1'b1;

  localparam logic [1:0] ST_DUE  = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [15:0] cell_index;
    logic [63:0] deadline;
    logic [63:0] now;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] due_index;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [63:0] deadline;
    logic [15:0] index;
  } entry_t;

  typedef struct packed {
    logic            wr_en;
    logic [PtrW-1:0] wr_addr;
    entry_t          wr_data;
    logic            rd_en;
    logic [PtrW-1:0] rd_addr;
  } mem_req_t;

endpackage

/* rtl/dotq_store.sv */
// Entry memory: one write port, one read port with registered read data.
// Depends on dotq_pkg for entry_t and mem_req_t.
`timescale 1ns / 1ps

module dotq_store
  import dotq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned AW          = 6
) (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output entry_t   rd_data_o
);

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr[AW-1:0]] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.rd_addr[AW-1:0]];
    end
  end

  assign rd_data_o = rd_q;

endmodule

/* rtl/dotq_seq.sv */
// Sequencer for the timer queue: ring pointers, shared deadline comparator
// and address adder, insertion shift walk and pop scan. Depends on dotq_pkg.
`timescale 1ns / 1ps

module dotq_seq
  import dotq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned AW          = 6,
  parameter int unsigned CW          = 7
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  input  logic      out_free_i,
  output logic      emit_o,
  output out_item_t emit_item_o,
  output mem_req_t  req_o,
  input  entry_t    rd_data_i
);

  localparam int unsigned SW = CW + 1;
  localparam logic [SW-1:0] DepthS = SW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_INS_RD  = 6'b000010,
    S_INS_CMP = 6'b000100,
    S_POP_RD  = 6'b001000,
    S_POP_CMP = 6'b010000,
    S_RESP    = 6'b100000
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] k_q, k_d;
  logic          pend_q, pend_d;
  logic [15:0]   pend_idx_q, pend_idx_d;
  logic [63:0]   key_q, key_d;
  entry_t        new_q, new_d;

  logic [CW-1:0] off;
  logic [SW-1:0] sum;
  logic [SW-1:0] sum_w;
  logic [AW-1:0] addr;
  logic          le;
  logic          due;

  // shared address adder with ring wrap
  always_comb begin
    case (state_q)
      S_INS_RD:  off = (pos_q == '0) ? '0 : pos_q - CW'(1);
      S_INS_CMP: off = pos_q;
      default:   off = k_q;
    endcase
    sum   = SW'(head_q) + SW'(off);
    sum_w = (sum >= DepthS) ? sum - DepthS : sum;
    addr  = sum_w[AW-1:0];
  end

  // shared deadline comparator
  assign le  = rd_data_i.deadline <= key_q;
  assign due = (k_q < count_q) && le;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    pos_d       = pos_q;
    k_d         = k_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    key_d       = key_q;
    new_d       = new_q;
    req_o       = '0;
    emit_o      = 1'b0;
    emit_item_o = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          new_d.deadline = in_item_i.deadline;
          new_d.index    = in_item_i.cell_index;
          if (in_item_i.mode == MODE_INSERT) begin
            key_d = in_item_i.deadline;
            if (count_q == DepthC) begin
              state_d = S_RESP;
            end else begin
              pos_d   = count_q;
              state_d = S_INS_RD;
            end
          end else begin
            key_d   = in_item_i.now;
            k_d     = '0;
            pend_d  = 1'b0;
            state_d = S_POP_RD;
          end
        end
      end
      S_INS_RD: begin
        if (pos_q == '0) begin
          req_o.wr_en   = 1'b1;
          req_o.wr_addr = PtrW'(addr);
          req_o.wr_data = new_q;
          count_d       = count_q + CW'(1);
          state_d       = S_IDLE;
        end else begin
          req_o.rd_en   = 1'b1;
          req_o.rd_addr = PtrW'(addr);
          state_d       = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        req_o.wr_en   = 1'b1;
        req_o.wr_addr = PtrW'(addr);
        if (le) begin
          req_o.wr_data = new_q;
          count_d       = count_q + CW'(1);
          state_d       = S_IDLE;
        end else begin
          req_o.wr_data = rd_data_i;
          pos_d         = pos_q - CW'(1);
          state_d       = S_INS_RD;
        end
      end
      S_POP_RD: begin
        req_o.rd_en   = 1'b1;
        req_o.rd_addr = PtrW'(addr);
        state_d       = S_POP_CMP;
      end
      S_POP_CMP: begin
        if (due) begin
          if (!pend_q) begin
            pend_d     = 1'b1;
            pend_idx_d = rd_data_i.index;
            k_d        = k_q + CW'(1);
            state_d    = S_POP_RD;
          end else if (out_free_i) begin
            emit_o                = 1'b1;
            emit_item_o.status    = ST_DUE;
            emit_item_o.due_index = pend_idx_q;
            emit_item_o.last      = 1'b0;
            pend_idx_d            = rd_data_i.index;
            k_d                   = k_q + CW'(1);
            state_d               = S_POP_RD;
          end
        end else if (out_free_i) begin
          emit_o           = 1'b1;
          emit_item_o.last = 1'b1;
          if (pend_q) begin
            emit_item_o.status    = ST_DUE;
            emit_item_o.due_index = pend_idx_q;
          end else begin
            emit_item_o.status = ST_NONE;
          end
          head_d  = addr;
          count_d = count_q - k_q;
          pend_d  = 1'b0;
          state_d = S_IDLE;
        end
      end
      S_RESP: begin
        if (out_free_i) begin
          emit_o             = 1'b1;
          emit_item_o.status = ST_FULL;
          emit_item_o.last   = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      pos_q   <= '0;
      k_q     <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      k_q     <= k_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    key_q      <= key_d;
    new_q      <= new_d;
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("entry count above depth");

  a_emit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |-> out_free_i)
    else $error("result issued while output register busy");

  a_idle_no_pend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_q)
    else $error("pending due entry left at idle");

  a_ins_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_CMP) |-> (pos_q != '0) && (pos_q <= count_q))
    else $error("insert walk position out of range");

  a_pop_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP_RD) |-> (k_q <= count_q))
    else $error("pop scan past entry count");

endmodule

/* rtl/deadline_ordered_timer_queue_top.sv */
// Top level of the deadline-ordered timer queue: sequencer, entry memory
// and output register. Depends on dotq_pkg, dotq_store and dotq_seq.
//
//   channel | signals                          | payload
//   in      | in_valid_i / in_ready_o          | in_item_i  (in_item_t)
//   out     | out_valid_o / out_ready_i        | out_item_o (out_item_t)
//
// Insert: each stored entry with a later deadline is read and shifted one slot
// toward the tail, then the new entry is written into the freed slot; a full
// queue answers with a full status and stores nothing.
// Pop: entries are examined in turn (due entries plus one) through the single
// memory read port with registered data feeding the shared 64-bit comparator.
// Reset clears control state, count and ring pointer; no memory clearing pass.
// A full output register stalls the sequencer until the result transfers.
`timescale 1ns / 1ps

module deadline_ordered_timer_queue_top
  import dotq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  mem_req_t  req;
  entry_t    rd_data;
  logic      emit;
  out_item_t emit_item;
  logic      out_free;
  logic      out_valid_q;
  out_item_t out_q;

  assign out_free = !out_valid_q || out_ready_i;

  dotq_seq #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .AW         (AW),
    .CW         (CW)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_free_i (out_free),
    .emit_o     (emit),
    .emit_item_o(emit_item),
    .req_o      (req),
    .rd_data_i  (rd_data)
  );

  dotq_store #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .AW         (AW)
  ) u_store (
    .clk_i    (clk_i),
    .req_i    (req),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= emit_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* dv/timer_queue_checker.sv */
// Checker for the deadline-ordered timer queue: watches both channels, keeps its own
// sorted entry list, predicts every result and compares field by field.
// Depends on dotq_pkg only.
`timescale 1ns / 1ps

module timer_queue_checker
  import dotq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_item_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  logic [63:0] slot_deadline [QUEUE_DEPTH];
  logic [15:0] slot_cell [QUEUE_DEPTH];
  int unsigned slot_count;
  out_item_t   expected_results [$];
  int unsigned fails;

  task automatic predict_timer_item(input in_item_t it);
    int unsigned pos;
    int unsigned due;
    int unsigned i;
    out_item_t   res;
    res = '0;
    res.last = 1'b1;
    if (it.mode == MODE_INSERT) begin
      if (slot_count >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
        expected_results.push_back(res);
      end else begin
        pos = 0;
        while (pos < slot_count && slot_deadline[pos] <= it.deadline) pos++;
        for (i = slot_count; i > pos; i--) begin
          slot_deadline[i] = slot_deadline[i-1];
          slot_cell[i]     = slot_cell[i-1];
        end
        slot_deadline[pos] = it.deadline;
        slot_cell[pos]     = it.cell_index;
        slot_count++;
      end
    end else begin
      due = 0;
      while (due < slot_count && slot_deadline[due] <= it.now) due++;
      if (due == 0) begin
        res.status = ST_NONE;
        expected_results.push_back(res);
      end else begin
        for (i = 0; i < due; i++) begin
          res.status    = ST_DUE;
          res.due_index = slot_cell[i];
          res.last      = (i + 1 == due);
          expected_results.push_back(res);
        end
        for (i = due; i < slot_count; i++) begin
          slot_deadline[i-due] = slot_deadline[i];
          slot_cell[i-due]     = slot_cell[i];
        end
        slot_count -= due;
      end
    end
  endtask

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_res;
    if (!rst_ni) begin
      slot_count = 0;
      expected_results.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d, due_index %0d, last %0d",
                 out_item_i.status, out_item_i.due_index, out_item_i.last);
          fails++;
        end else begin
          exp_res = expected_results.pop_front();
          check_field("status", 16'(exp_res.status), 16'(out_item_i.status));
          check_field("due_index", exp_res.due_index, out_item_i.due_index);
          check_field("last", 16'(exp_res.last), 16'(out_item_i.last));
        end
      end
      if (in_valid_i && in_ready_i) predict_timer_item(in_item_i);
      fail_count_o <= fails;
      pending_o    <= expected_results.size();
    end
  end

endmodule

/* dv/tb.sv */
// Testbench top for the deadline-ordered timer queue: clock, reset, directed and
// random schedule/pop traffic with idling phases. Depends on dotq_pkg,
// deadline_ordered_timer_queue_top and timer_queue_checker.
`timescale 1ns / 1ps

module tb;
  import dotq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 64;
  localparam logic [63:0] TICK_MAX    = '1;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_item_o;
  int unsigned fail_count;
  int unsigned results_pending;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned phase_items;
  logic [63:0] tick;

  always #5 clk_i = ~clk_i;

  deadline_ordered_timer_queue_top #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  timer_queue_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_i  (out_item_o),
    .fail_count_o(fail_count),
    .pending_o   (results_pending)
  );

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_item(input logic mode, input logic [15:0] cell_idx,
                           input logic [63:0] dl, input logic [63:0] now_tick);
    in_item_t it;
    it.mode       = mode;
    it.cell_index = cell_idx;
    it.deadline   = dl;
    it.now        = now_tick;
    if ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    phase_items++;
  endtask

  task automatic schedule(input logic [15:0] cell_idx, input logic [63:0] dl);
    send_item(MODE_INSERT, cell_idx, dl, rand64());
  endtask

  task automatic expire(input logic [63:0] now_tick);
    send_item(MODE_POP, 16'($urandom), rand64(), now_tick);
  endtask

  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
  endtask

  task automatic fill_and_drain();
    int unsigned i;
    for (i = 0; i < QUEUE_DEPTH + 2; i++) schedule(16'($urandom), tick + $urandom_range(20));
    expire(TICK_MAX);
  endtask

  task automatic run_sequence();
    int unsigned kind;
    int unsigned n;
    int unsigned i;
    kind = $urandom_range(99);
    if (kind < 15) begin
      send_item(1'($urandom_range(1)), 16'($urandom), rand64(), rand64());
    end else if (kind < 20) begin
      expire(TICK_MAX);
    end else begin
      n = $urandom_range(1, 12);
      for (i = 0; i < n; i++) schedule(16'($urandom), tick + $urandom_range(40));
      tick = tick + $urandom_range(50);
      expire(tick);
      if ($urandom_range(3) == 0) expire(tick);
    end
  endtask

  initial begin
    int unsigned phase;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    out_ready_i <= 1'b0;
    tick = 64'd100;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    expire(64'd0);
    expire(TICK_MAX);
    schedule(16'hFFFF, TICK_MAX);
    schedule(16'h0000, 64'd0);
    schedule(16'h0001, 64'd0);
    schedule(16'h0002, 64'd5);
    schedule(16'h0003, 64'd5);
    schedule(16'h0004, 64'd3);
    expire(64'd0);
    expire(64'd4);
    expire(64'd4);
    schedule(16'h0005, TICK_MAX);
    expire(TICK_MAX - 1);
    expire(TICK_MAX);
    expire(TICK_MAX);
    wait_results_done();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 53;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 53;
        end
        default: begin
          gap_pct   = 28;
          stall_pct = 28;
        end
      endcase
      phase_items = 0;
      if (phase == 0 || phase == 3) fill_and_drain();
      while (phase_items < 85) run_sequence();
      wait_results_done();
    end

    repeat (300) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("deadline_ordered_timer_queue_top: match");
    end else begin
      $display("deadline_ordered_timer_queue_top: mismatch");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("deadline_ordered_timer_queue_top: mismatch");
    $finish;
  end

endmodule
